/* rtl/ptt_pkg.sv */
// Package for the periodic timer table: operation, result and status codes,
// the sequencer state type and the default sizes.
// Depends on nothing; used by periodic_timer_table.
package ptt_pkg;

    // default sizes
    localparam int DEF_MAX_TIMERS = 16;
    localparam int DEF_KEY_BITS   = 16;
    localparam int DEF_COUNT_BITS = 24;

    // operation codes of an input word
    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_ADD  = 2'd1;
    localparam logic [1:0] FUNC_DEL  = 2'd2;

    // kind of a result word
    localparam logic [1:0] KIND_FIRE = 2'd0;
    localparam logic [1:0] KIND_ADD  = 2'd1;
    localparam logic [1:0] KIND_DEL  = 2'd2;

    // status of a result word
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_PERIOD = 2'd1;
    localparam logic [1:0] ST_FULL       = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TK_RD,
        S_TK_PROC,
        S_TK_END,
        S_DEL_RD,
        S_DEL_CHK,
        S_SH_RD,
        S_SH_WR,
        S_RESP
    } t_state;

endpackage

/* rtl/periodic_timer_table.sv */
// Periodic timer table: timers kept in one synchronous memory in the order
// they were added, walked and updated by a read-modify-write sequencer.
// Depends on ptt_pkg.
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  ---------------------------------------
//  in        input      i_in_valid / o_in_ready   i_func i_start_delay i_period i_timer_key
//  out       output     o_out_valid / i_out_ready o_kind o_fired_key o_status o_last
//
// Steps: a tick reads each live timer and writes it back (one memory read and
// one write-back per timer, the memory's single read port sets the pace). An accepted add
// writes its entry in the idle cycle that takes the word. A delete reads each
// timer up to and including the match (or every timer when none matches), then
// moves every timer behind it down by one. Adds and deletes end with a status word.
// Reset clears the timer count, the sequencer and the output valid; the memory
// keeps its contents, since only entries below the count are ever read.
// Stalls: a word is taken only while the sequencer is idle. The walk holds when
// a timer fires while an earlier fired word is still held back and the output
// register has not been taken; status words and the final fired word wait for
// the output register in the same way.
module periodic_timer_table #(
    parameter int MAX_TIMERS = ptt_pkg::DEF_MAX_TIMERS,
    parameter int KEY_BITS   = ptt_pkg::DEF_KEY_BITS,
    parameter int COUNT_BITS = ptt_pkg::DEF_COUNT_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_func,
    input  logic [COUNT_BITS-1:0] i_start_delay,
    input  logic [COUNT_BITS-1:0] i_period,
    input  logic [KEY_BITS-1:0]   i_timer_key,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_kind,
    output logic [KEY_BITS-1:0]   o_fired_key,
    output logic [1:0]            o_status,
    output logic                  o_last
);
    import ptt_pkg::*;

    // counts carry COUNT_BITS-1 bits: only nonnegative values are stored
    localparam int RB = COUNT_BITS - 1;
    localparam int EW = KEY_BITS + 2 * RB;
    localparam int IW = $clog2(MAX_TIMERS);
    localparam int CW = $clog2(MAX_TIMERS + 1);

    // timer entry layout: {key, period, remaining}
    logic [EW-1:0] r_mem [MAX_TIMERS];
    logic [EW-1:0] r_rd_data;

    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    t_state        r_state, n_state;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_count, n_count;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [1:0]    r_status, n_status;
    logic [1:0]    r_kind, n_kind;
    // fired word held back until it is known whether another timer fires
    logic          r_pend_v, n_pend_v;
    logic [KEY_BITS-1:0] r_pend_key, n_pend_key;

    logic                r_o_valid;
    logic [1:0]          r_o_kind;
    logic [KEY_BITS-1:0] r_o_key;
    logic [1:0]          r_o_status;
    logic                r_o_last;

    logic                push;
    logic [1:0]          push_kind;
    logic [KEY_BITS-1:0] push_key;
    logic [1:0]          push_status;
    logic                push_last;
    logic                out_free;

    logic [KEY_BITS-1:0] rd_key;
    logic [RB-1:0]       rd_period;
    logic [RB-1:0]       rd_rem;
    logic [CW-1:0]       idx_p1;
    logic                add_bad;
    logic [RB-1:0]       add_delay;

    assign rd_key    = r_rd_data[2*RB +: KEY_BITS];
    assign rd_period = r_rd_data[RB +: RB];
    assign rd_rem    = r_rd_data[0 +: RB];
    assign idx_p1    = r_idx + CW'(1);

    // reject a period that is zero or negative; clamp a negative delay to zero
    assign add_bad   = i_period[COUNT_BITS-1] || (i_period == '0);
    assign add_delay = i_start_delay[COUNT_BITS-1] ? '0 : i_start_delay[RB-1:0];

    // output register can load when empty or being drained this cycle
    assign out_free   = !r_o_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    // Timer memory: one read port with registered data, one write port.
    // The walk never reads an entry that it has just written back, so no
    // forwarding path is needed.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_key      <= n_key;
        r_status   <= n_status;
        r_kind     <= n_kind;
        r_pend_key <= n_pend_key;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= push || (r_o_valid && !i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_o_kind   <= push_kind;
            r_o_key    <= push_key;
            r_o_status <= push_status;
            r_o_last   <= push_last;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_kind      = r_o_kind;
    assign o_fired_key = r_o_key;
    assign o_status    = r_o_status;
    assign o_last      = r_o_last;

    // Sequencer: next state, memory controls and result pushes.
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_count     = r_count;
        n_key       = r_key;
        n_status    = r_status;
        n_kind      = r_kind;
        n_pend_v    = r_pend_v;
        n_pend_key  = r_pend_key;
        rd_en       = 1'b0;
        rd_addr     = r_idx[IW-1:0];
        wr_en       = 1'b0;
        wr_addr     = r_idx[IW-1:0];
        wr_data     = r_rd_data;
        push        = 1'b0;
        push_kind   = KIND_FIRE;
        push_key    = r_pend_key;
        push_status = ST_OK;
        push_last   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_func)
                        FUNC_TICK: begin
                            n_idx    = '0;
                            n_pend_v = 1'b0;
                            n_state  = S_TK_RD;
                        end
                        FUNC_ADD: begin
                            n_kind  = KIND_ADD;
                            n_state = S_RESP;
                            if (add_bad) begin
                                n_status = ST_BAD_PERIOD;
                            end else if (r_count == CW'(MAX_TIMERS)) begin
                                n_status = ST_FULL;
                            end else begin
                                // append at the tail of the order
                                wr_en    = 1'b1;
                                wr_addr  = r_count[IW-1:0];
                                wr_data  = {i_timer_key, i_period[RB-1:0], add_delay};
                                n_count  = r_count + CW'(1);
                                n_status = ST_OK;
                            end
                        end
                        FUNC_DEL: begin
                            n_key   = i_timer_key;
                            n_kind  = KIND_DEL;
                            n_idx   = '0;
                            n_state = S_DEL_RD;
                        end
                        default: begin
                            // unused code: drop the word
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_TK_RD: begin
                if (r_idx < r_count) begin
                    rd_en   = 1'b1;
                    n_state = S_TK_PROC;
                end else begin
                    n_state = r_pend_v ? S_TK_END : S_IDLE;
                end
            end

            S_TK_PROC: begin
                if (rd_rem != '0) begin
                    wr_en   = 1'b1;
                    wr_data = {rd_key, rd_period, rd_rem - RB'(1)};
                    n_idx   = idx_p1;
                    n_state = S_TK_RD;
                end else if (!r_pend_v || out_free) begin
                    // fire: release the held word, hold this one, reload
                    push       = r_pend_v;
                    n_pend_v   = 1'b1;
                    n_pend_key = rd_key;
                    wr_en      = 1'b1;
                    wr_data    = {rd_key, rd_period, rd_period - RB'(1)};
                    n_idx      = idx_p1;
                    n_state    = S_TK_RD;
                end
            end

            S_TK_END: begin
                if (out_free) begin
                    push      = 1'b1;
                    push_last = 1'b1;
                    n_pend_v  = 1'b0;
                    n_state   = S_IDLE;
                end
            end

            S_DEL_RD: begin
                if (r_idx < r_count) begin
                    rd_en   = 1'b1;
                    n_state = S_DEL_CHK;
                end else begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_RESP;
                end
            end

            S_DEL_CHK: begin
                if (rd_key == r_key) begin
                    n_state = S_SH_RD;
                end else begin
                    n_idx   = idx_p1;
                    n_state = S_DEL_RD;
                end
            end

            // move every later entry down by one
            S_SH_RD: begin
                if (idx_p1 < r_count) begin
                    rd_en   = 1'b1;
                    rd_addr = idx_p1[IW-1:0];
                    n_state = S_SH_WR;
                end else begin
                    n_count  = r_count - CW'(1);
                    n_status = ST_OK;
                    n_state  = S_RESP;
                end
            end

            S_SH_WR: begin
                wr_en   = 1'b1;
                n_idx   = idx_p1;
                n_state = S_SH_RD;
            end

            S_RESP: begin
                if (out_free) begin
                    push        = 1'b1;
                    push_kind   = r_kind;
                    push_key    = '0;
                    push_status = r_status;
                    push_last   = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* tb/tb_periodic_timer_table.sv */
// Self-checking testbench for periodic_timer_table: directed plan, then random words,
// result words checked against an in-bench timer table predictor or a hand-typed status.
// Depends on ptt_pkg and periodic_timer_table.
`timescale 1ns / 1ps

module tb_periodic_timer_table;
    import ptt_pkg::*;

    localparam int NT = DEF_MAX_TIMERS;
    localparam int KB = DEF_KEY_BITS;
    localparam int CB = DEF_COUNT_BITS;

    // func value 3 is unused by the block: the word is swallowed silently
    localparam logic [1:0] FUNC_NOP = 2'd3;

    localparam int RAND_WORDS = 260;
    localparam int HOLD_AT    = 150;   // input words taken before the long hold-off
    localparam int HOLD_LEN   = 400;   // receiver hold-off, in cycles
    localparam int DRAIN      = 100;
    localparam int IDLE_LIMIT = 4000;  // cycles without any handshake

    typedef struct packed {
        logic [1:0]    func;
        logic [CB-1:0] delay;
        logic [CB-1:0] period;
        logic [KB-1:0] key;
    } t_word;

    typedef struct packed {
        logic [1:0]    kind;
        logic [KB-1:0] key;
        logic [1:0]    status;
        logic          last;
    } t_res;

    // one row of the directed plan; chk rows carry a hand-typed status
    typedef struct {
        t_word      w;
        int         rep;
        bit         chk;
        logic [1:0] st;
    } t_row;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_in_valid = 1'b0;
    logic          o_in_ready;
    logic [1:0]    i_func = FUNC_TICK;
    logic [CB-1:0] i_start_delay = '0;
    logic [CB-1:0] i_period = '0;
    logic [KB-1:0] i_timer_key = '0;
    logic          o_out_valid;
    logic          i_out_ready = 1'b0;
    logic [1:0]    o_kind;
    logic [KB-1:0] o_fired_key;
    logic [1:0]    o_status;
    logic          o_last;

    periodic_timer_table i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_start_delay (i_start_delay),
        .i_period      (i_period),
        .i_timer_key   (i_timer_key),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_fired_key   (o_fired_key),
        .o_status      (o_status),
        .o_last        (o_last)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Timer table predictor: a shadow of the live timers in add order.
    // ------------------------------------------------------------------
    logic          tmr_live [NT];
    logic [KB-1:0] tmr_key [NT];
    logic [CB-2:0] tmr_period [NT];
    logic [CB-2:0] tmr_left [NT];
    int            tmr_order [NT];
    int            tmr_count = 0;

    t_res   step_res [NT];   // result words caused by the latest input word
    int     step_n;
    t_res   pending_q [$];   // result words still owed by the block
    t_row   plan_q [$];

    int     words_in = 0;
    int     err_cnt = 0;
    int     burst_left = 0;

    task automatic tick_timers();
        int s;
        step_n = 0;
        for (int i = 0; i < tmr_count; i++) begin
            s = tmr_order[i];
            if (tmr_left[s] != 0) begin
                tmr_left[s] = tmr_left[s] - 1'b1;
            end else begin
                // fire: emit the key and reload period minus one
                step_res[step_n] = t_res'{KIND_FIRE, tmr_key[s], ST_OK, 1'b0};
                step_n++;
                tmr_left[s] = tmr_period[s] - 1'b1;
            end
        end
        if (step_n > 0)
            step_res[step_n-1].last = 1'b1;
    endtask

    function automatic logic [1:0] add_timer(input t_word w);
        int s;
        // a period with the sign bit set or zero is refused before the full check
        if (w.period[CB-1] || w.period == '0)
            return ST_BAD_PERIOD;
        if (tmr_count >= NT)
            return ST_FULL;
        s = 0;
        while (s < NT && tmr_live[s])
            s++;
        if (s >= NT)
            return ST_FULL;
        tmr_live[s]   = 1'b1;
        tmr_key[s]    = w.key;
        tmr_period[s] = w.period[CB-2:0];
        tmr_left[s]   = w.delay[CB-1] ? '0 : w.delay[CB-2:0];
        tmr_order[tmr_count] = s;
        tmr_count++;
        return ST_OK;
    endfunction

    function automatic logic [1:0] drop_timer(input logic [KB-1:0] key);
        int s;
        // remove the oldest match and close the gap in the add order
        for (int i = 0; i < tmr_count; i++) begin
            s = tmr_order[i];
            if (tmr_key[s] == key) begin
                tmr_live[s] = 1'b0;
                for (int j = i; j + 1 < tmr_count; j++)
                    tmr_order[j] = tmr_order[j+1];
                tmr_count--;
                return ST_OK;
            end
        end
        return ST_NOT_FOUND;
    endfunction

    task automatic predict_word(input t_word w);
        step_n = 0;
        case (w.func)
            FUNC_TICK: tick_timers();
            FUNC_ADD: begin
                step_res[0] = t_res'{KIND_ADD, '0, add_timer(w), 1'b1};
                step_n = 1;
            end
            FUNC_DEL: begin
                step_res[0] = t_res'{KIND_DEL, '0, drop_timer(w.key), 1'b1};
                step_n = 1;
            end
            default: step_n = 0;
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        err_cnt++;
    endtask

    // ------------------------------------------------------------------
    // Sender: offer one word, hold it until taken, then book the results.
    // Bursts of random length, random gaps between them, gap 0 now and then.
    // ------------------------------------------------------------------
    task automatic send_word(input t_word w, input bit chk, input logic [1:0] st);
        int gap;
        i_in_valid    <= 1'b1;
        i_func        <= w.func;
        i_start_delay <= w.delay;
        i_period      <= w.period;
        i_timer_key   <= w.key;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        words_in++;
        predict_word(w);
        if (chk) begin
            // hand-typed status: trust the row, still advance the shadow table
            pending_q.push_back(t_res'{(w.func == FUNC_ADD) ? KIND_ADD : KIND_DEL, '0, st,
                                       1'b1});
        end else begin
            for (int i = 0; i < step_n; i++)
                pending_q.push_back(step_res[i]);
        end
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic plan(input logic [1:0] f, input logic [CB-1:0] d, input logic [CB-1:0] p,
                        input logic [KB-1:0] k, input int rep, input bit chk,
                        input logic [1:0] st);
        plan_q.push_back(t_row'{t_word'{f, d, p, k}, rep, chk, st});
    endtask

    function automatic logic [KB-1:0] pick_key();
        logic [KB-1:0] pool [6] = '{16'h0000, 16'hFFFF, 16'h1234, 16'h8001, 16'h5A5A, 16'h00FF};
        // a small pool makes deletes hit and duplicate keys pile up
        if ($urandom_range(0, 7) == 0)
            return KB'($urandom);
        return pool[$urandom_range(0, 5)];
    endfunction

    function automatic logic [CB-1:0] pick_delay();
        case ($urandom_range(0, 9))
            0:       return CB'($urandom);
            1:       return {1'b1, (CB-1)'($urandom)};   // negative, clamps to zero
            2:       return '0;
            default: return CB'($urandom_range(0, 4));
        endcase
    endfunction

    function automatic logic [CB-1:0] pick_period();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return {1'b1, (CB-1)'($urandom)};   // negative, refused
            2:       return {1'b0, (CB-1)'($urandom)};   // huge but legal
            3:       return CB'($urandom);
            default: return CB'($urandom_range(1, 4));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stim
        t_row  r;
        t_word w;
        int    sent;
        int    pick;
        bit    fill;

        for (int i = 0; i < NT; i++)
            tmr_live[i] = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed plan: empty table, period edges, delay clamp, fill to full
        plan(FUNC_TICK, '0, '0, '0, 1, 1'b0, ST_OK);
        plan(FUNC_DEL, '0, '0, 16'h1234, 1, 1'b1, ST_NOT_FOUND);
        plan(FUNC_ADD, 24'h000005, 24'h000000, 16'h0001, 1, 1'b1, ST_BAD_PERIOD);
        plan(FUNC_ADD, 24'h000000, 24'hFFFFFF, 16'h0002, 1, 1'b1, ST_BAD_PERIOD);
        plan(FUNC_ADD, 24'h7FFFFF, 24'h800000, 16'h0003, 1, 1'b1, ST_BAD_PERIOD);
        plan(FUNC_ADD, 24'hFFFFFF, 24'h000001, 16'hFFFF, 1, 1'b1, ST_OK);
        plan(FUNC_ADD, 24'h800000, 24'h7FFFFF, 16'h0000, 1, 1'b1, ST_OK);
        plan(FUNC_ADD, 24'h7FFFFF, 24'h000003, 16'hA5A5, 1, 1'b1, ST_OK);
        plan(FUNC_TICK, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 1, 1'b0, ST_OK);
        plan(FUNC_NOP, 24'hFFFFFF, 24'h000001, 16'hFFFF, 1, 1'b0, ST_OK);
        plan(FUNC_ADD, 24'h000001, 24'h000002, 16'h0100, 13, 1'b1, ST_OK);
        plan(FUNC_ADD, 24'h000000, 24'h000005, 16'h0200, 1, 1'b1, ST_FULL);
        plan(FUNC_ADD, 24'h000000, 24'h000000, 16'h0201, 1, 1'b1, ST_BAD_PERIOD);
        plan(FUNC_TICK, '0, '0, '0, 1, 1'b0, ST_OK);
        plan(FUNC_DEL, '0, '0, 16'hFFFF, 1, 1'b1, ST_OK);
        plan(FUNC_DEL, '0, '0, 16'hFFFF, 1, 1'b1, ST_NOT_FOUND);

        foreach (plan_q[i]) begin
            r = plan_q[i];
            for (int k = 0; k < r.rep; k++) begin
                w = r.w;
                w.key = r.w.key + KB'(k);
                send_word(w, r.chk, r.st);
            end
        end

        // random part: alternate fill and drain phases so the table both
        // runs full and empties out; func 3 noise does not count
        sent = 0;
        while (sent < RAND_WORDS) begin
            fill = ((sent / 30) % 2) == 0;
            pick = $urandom_range(0, 99);
            w.delay  = pick_delay();
            w.period = pick_period();
            w.key    = pick_key();
            if (pick < 3) begin
                w.func = FUNC_NOP;
            end else begin
                if (pick < (fill ? 50 : 25))
                    w.func = FUNC_ADD;
                else if (pick < (fill ? 62 : 55))
                    w.func = FUNC_DEL;
                else
                    w.func = FUNC_TICK;
                sent++;
            end
            send_word(w, 1'b0, ST_OK);
        end
        i_in_valid <= 1'b0;

        // wait out every owed word, then watch for strays
        while (pending_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: its own ready pattern, cycling through always-ready, coin
    // flip, three-of-four, and mostly-stalled. Once, mid-run, hold off long
    // enough for the block to back up into its input.
    // ------------------------------------------------------------------
    initial begin : sink
        int unsigned cyc;
        bit          held;
        cyc  = 0;
        held = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (!held && words_in >= HOLD_AT) begin
                held = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
            end
            case ((cyc / 64) % 4)
                0:       i_out_ready <= 1'b1;
                1:       i_out_ready <= 1'($urandom_range(0, 1));
                2:       i_out_ready <= (cyc % 4) != 3;
                default: i_out_ready <= $urandom_range(0, 3) == 0;
            endcase
            cyc++;
            @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each taken word with the oldest owed one.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_out
        t_res got;
        t_res want;
        if (o_out_valid && i_out_ready) begin
            got = t_res'{o_kind, o_fired_key, o_status, o_last};
            if (pending_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word kind=%0d key=%h st=%0d last=%0d",
                                          got.kind, got.key, got.status, got.last));
            end else begin
                want = pending_q.pop_front();
                if (got != want)
                    report_mismatch($sformatf(
                        "got kind=%0d key=%h st=%0d last=%0d, want kind=%0d key=%h st=%0d last=%0d",
                        got.kind, got.key, got.status, got.last,
                        want.kind, want.key, want.status, want.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if neither channel moves for too long.
    // ------------------------------------------------------------------
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle = 0;
            else
                idle++;
        end
        $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("FAIL");
        $finish;
    end

endmodule

/* filelist.f */
rtl/ptt_pkg.sv
rtl/periodic_timer_table.sv
tb/tb_periodic_timer_table.sv
